/* rtl/owm_pkg.sv */
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants of the multi-line 1-wire bus master: command
// kinds, sequencer phases, timing register indexes and their reset values.
// ----------------------------------------------------------------------------
package owm_pkg;

    // Default geometry
    localparam int LINES_DEFAULT      = 8;
    localparam int TIMER_BITS_DEFAULT = 10;

    // Field widths
    localparam int KIND_W    = 3;
    localparam int CFG_W     = 10;
    localparam int CFG_COUNT = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_SEL_W = $clog2(CFG_COUNT);

    // Command kinds carried by each input transfer
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 3'd0,
        KIND_RESET   = 3'd1,
        KIND_WRITE   = 3'd2,
        KIND_READ    = 3'd3,
        KIND_RELEASE = 3'd4
    } kind_t;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_W_LOW      = 4'd1,
        PH_W_SLOT     = 4'd2,
        PH_R_LOW      = 4'd3,
        PH_R_SAMPLE   = 4'd4,
        PH_R_SLOT     = 4'd5,
        PH_RS_HIGH    = 4'd6,
        PH_RS_LOW     = 4'd7,
        PH_RS_PSAMPLE = 4'd8,
        PH_RS_PCHECK  = 4'd9,
        PH_RS_TAIL    = 4'd10
    } phase_t;

    // Timing register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WSLOT    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RSAMPLE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RSLOT    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RHIGH    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RLOW     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PSAMPLE  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PCHECK   = 4'd7;

    // Timing register reset values, in microseconds
    localparam logic [CFG_W-1:0] RST_RECOVERY = 10'd2;
    localparam logic [CFG_W-1:0] RST_WSLOT    = 10'd60;
    localparam logic [CFG_W-1:0] RST_RSAMPLE  = 10'd13;
    localparam logic [CFG_W-1:0] RST_RSLOT    = 10'd50;
    localparam logic [CFG_W-1:0] RST_RHIGH    = 10'd250;
    localparam logic [CFG_W-1:0] RST_RLOW     = 10'd550;
    localparam logic [CFG_W-1:0] RST_PSAMPLE  = 10'd70;
    localparam logic [CFG_W-1:0] RST_PCHECK   = 10'd300;

endpackage

/* rtl/multi_line_one_wire_master_top.sv */
// ----------------------------------------------------------------------------
// multi_line_one_wire_master_top
// 1-wire master driving several bus lines in parallel through level and
// direction shadows, sequenced by microsecond tick transfers.
// ----------------------------------------------------------------------------
// Every input transfer (a tick or a command) yields exactly one result, offered
// on the result channel in the next cycle, so the block sustains one item per
// cycle as long as the result channel does not stall. The figure is set by the
// single pass of sequencer logic between the phase/shadow registers and the
// result register; s_ready stays high whenever the result register is empty or
// being taken in the same cycle. Timing registers are written through the cfg
// channel, which is always ready; unknown indexes are ignored.
module multi_line_one_wire_master_top #(
    parameter int LINES      = owm_pkg::LINES_DEFAULT,
    parameter int TIMER_BITS = owm_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    // Configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [owm_pkg::CFG_W-1:0]    cfg_data,

    // Input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [owm_pkg::KIND_W-1:0]   s_kind,
    input  logic [LINES-1:0]             s_line_mask,
    input  logic                         s_write_value,
    input  logic [LINES-1:0]             s_pin_levels,

    // Result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [LINES-1:0]             m_direction_mask,
    output logic [LINES-1:0]             m_level_mask,
    output logic                         m_busy_res,
    output logic                         m_done_res,
    output logic [LINES-1:0]             m_result_mask,
    output logic                         m_rejected
);

    import owm_pkg::*;

    localparam int WIDE_W = TIMER_BITS + CFG_W;

    // Timing registers
    logic [CFG_W-1:0] cfg_reg [CFG_COUNT];

    // Sequencer state
    phase_t                phase_reg,     phase_next;
    logic [TIMER_BITS-1:0] timer_reg,     timer_next;
    logic [LINES-1:0]      level_reg,     level_next;
    logic [LINES-1:0]      dir_reg,       dir_next;
    logic [LINES-1:0]      saved_lvl_reg, saved_lvl_next;
    logic [LINES-1:0]      saved_dir_reg, saved_dir_next;
    logic [LINES-1:0]      active_reg,    active_next;
    logic [LINES-1:0]      acc_reg,       acc_next;
    logic                  bit_reg,       bit_next;

    // Result register
    logic                  m_valid_reg;
    logic [LINES-1:0]      res_dir_reg, res_lvl_reg, res_mask_reg;
    logic                  res_busy_reg, res_done_reg, res_rej_reg;

    logic                  done_c, rej_c;
    logic [LINES-1:0]      result_c;
    logic [LINES-1:0]      present_c;
    logic [TIMER_BITS-1:0] timer_dec;
    logic                  in_xfer;

    // Load a phase timer from a timing register, fitted to the timer width
    function automatic logic [TIMER_BITS-1:0] load_time(input logic [CFG_W-1:0] v);
        logic [WIDE_W-1:0] wide;
        wide = {{TIMER_BITS{1'b0}}, v};
        return wide[TIMER_BITS-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_xfer   = s_valid && s_ready;

    // Write timing registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[REG_RECOVERY[CFG_SEL_W-1:0]] <= RST_RECOVERY;
            cfg_reg[REG_WSLOT[CFG_SEL_W-1:0]]    <= RST_WSLOT;
            cfg_reg[REG_RSAMPLE[CFG_SEL_W-1:0]]  <= RST_RSAMPLE;
            cfg_reg[REG_RSLOT[CFG_SEL_W-1:0]]    <= RST_RSLOT;
            cfg_reg[REG_RHIGH[CFG_SEL_W-1:0]]    <= RST_RHIGH;
            cfg_reg[REG_RLOW[CFG_SEL_W-1:0]]     <= RST_RLOW;
            cfg_reg[REG_PSAMPLE[CFG_SEL_W-1:0]]  <= RST_PSAMPLE;
            cfg_reg[REG_PCHECK[CFG_SEL_W-1:0]]   <= RST_PCHECK;
        end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(CFG_COUNT))) begin
            cfg_reg[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
        end
    end

    assign timer_dec = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;
    assign present_c = ~acc_reg & active_reg;

    // Next state and result for one transfer
    always_comb begin
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        level_next     = level_reg;
        dir_next       = dir_reg;
        saved_lvl_next = saved_lvl_reg;
        saved_dir_next = saved_dir_reg;
        active_next    = active_reg;
        acc_next       = acc_reg;
        bit_next       = bit_reg;
        done_c         = 1'b0;
        rej_c          = 1'b0;
        result_c       = '0;

        if (s_kind == KIND_TICK) begin
            // Advance time and close the phase when the timer runs out
            if (phase_reg != PH_IDLE) begin
                timer_next = timer_dec;
                if (timer_dec == '0) begin
                    case (phase_reg)
                        PH_W_LOW: begin
                            if (bit_reg) begin
                                level_next = saved_lvl_reg;
                            end
                            phase_next = PH_W_SLOT;
                            timer_next = load_time(cfg_reg[REG_WSLOT[CFG_SEL_W-1:0]]);
                        end
                        PH_W_SLOT: begin
                            level_next = saved_lvl_reg;
                            phase_next = PH_IDLE;
                            done_c     = 1'b1;
                        end
                        PH_R_LOW: begin
                            level_next = saved_lvl_reg;
                            dir_next   = saved_dir_reg & ~active_reg;
                            phase_next = PH_R_SAMPLE;
                            timer_next = load_time(cfg_reg[REG_RSAMPLE[CFG_SEL_W-1:0]]);
                        end
                        PH_R_SAMPLE: begin
                            acc_next   = s_pin_levels & active_reg;
                            phase_next = PH_R_SLOT;
                            timer_next = load_time(cfg_reg[REG_RSLOT[CFG_SEL_W-1:0]]);
                        end
                        PH_R_SLOT: begin
                            dir_next   = saved_dir_reg;
                            phase_next = PH_IDLE;
                            done_c     = 1'b1;
                            result_c   = acc_reg;
                        end
                        PH_RS_HIGH: begin
                            dir_next   = saved_dir_reg | active_reg;
                            level_next = saved_lvl_reg & ~active_reg;
                            phase_next = PH_RS_LOW;
                            timer_next = load_time(cfg_reg[REG_RLOW[CFG_SEL_W-1:0]]);
                        end
                        PH_RS_LOW: begin
                            dir_next   = saved_dir_reg & ~active_reg;
                            level_next = saved_lvl_reg | active_reg;
                            phase_next = PH_RS_PSAMPLE;
                            timer_next = load_time(cfg_reg[REG_PSAMPLE[CFG_SEL_W-1:0]]);
                        end
                        PH_RS_PSAMPLE: begin
                            acc_next   = s_pin_levels;
                            phase_next = PH_RS_PCHECK;
                            timer_next = load_time(cfg_reg[REG_PCHECK[CFG_SEL_W-1:0]]);
                        end
                        PH_RS_PCHECK: begin
                            // A line that is still low at the check is not present
                            acc_next   = acc_reg | ~s_pin_levels;
                            phase_next = PH_RS_TAIL;
                            timer_next = load_time(cfg_reg[REG_RHIGH[CFG_SEL_W-1:0]]);
                        end
                        PH_RS_TAIL: begin
                            dir_next   = saved_dir_reg | present_c;
                            level_next = saved_lvl_reg | present_c;
                            phase_next = PH_IDLE;
                            done_c     = 1'b1;
                            result_c   = present_c;
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end else if (s_kind inside {KIND_RESET, KIND_WRITE, KIND_READ, KIND_RELEASE}) begin
            if (phase_reg != PH_IDLE) begin
                // Drop a command that arrives mid-sequence
                rej_c = 1'b1;
            end else begin
                active_next    = s_line_mask;
                saved_lvl_next = level_reg;
                saved_dir_next = dir_reg;
                case (s_kind)
                    KIND_RESET: begin
                        level_next = level_reg | s_line_mask;
                        phase_next = PH_RS_HIGH;
                        timer_next = load_time(cfg_reg[REG_RHIGH[CFG_SEL_W-1:0]]);
                    end
                    KIND_WRITE: begin
                        bit_next   = s_write_value;
                        level_next = level_reg & ~s_line_mask;
                        phase_next = PH_W_LOW;
                        timer_next = load_time(cfg_reg[REG_RECOVERY[CFG_SEL_W-1:0]]);
                    end
                    KIND_READ: begin
                        level_next = level_reg & ~s_line_mask;
                        phase_next = PH_R_LOW;
                        timer_next = load_time(cfg_reg[REG_RECOVERY[CFG_SEL_W-1:0]]);
                    end
                    default: begin
                        // Release lines at once
                        dir_next   = dir_reg & ~s_line_mask;
                        level_next = level_reg & ~s_line_mask;
                        done_c     = 1'b1;
                    end
                endcase
            end
        end
    end

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            level_reg     <= '0;
            dir_reg       <= '0;
            saved_lvl_reg <= '0;
            saved_dir_reg <= '0;
            active_reg    <= '0;
            acc_reg       <= '0;
            bit_reg       <= 1'b0;
        end else if (in_xfer) begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            level_reg     <= level_next;
            dir_reg       <= dir_next;
            saved_lvl_reg <= saved_lvl_next;
            saved_dir_reg <= saved_dir_next;
            active_reg    <= active_next;
            acc_reg       <= acc_next;
            bit_reg       <= bit_next;
        end
    end

    // Hold the result until the downstream transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            res_dir_reg  <= dir_next;
            res_lvl_reg  <= level_next;
            res_busy_reg <= (phase_next != PH_IDLE);
            res_done_reg <= done_c;
            res_mask_reg <= result_c;
            res_rej_reg  <= rej_c;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_direction_mask = res_dir_reg;
    assign m_level_mask     = res_lvl_reg;
    assign m_busy_res       = res_busy_reg;
    assign m_done_res       = res_done_reg;
    assign m_result_mask    = res_mask_reg;
    assign m_rejected       = res_rej_reg;

endmodule

/* sim/multi_line_one_wire_master_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_line_one_wire_master_top_test
// Self-checking bench for the multi-line 1-wire master. A directed table runs
// first with the power-on slot timing and short reset phases, and covers
// release, the spare kinds, a rejected command and a full reset with presence
// detect. Random command sequences with random pin levels follow under small,
// zero and mixed timing. A cycle-true model of the sequencer predicts every
// result transfer not typed in the table, and both channels stall at random in all but the mixed-timing run.
// ----------------------------------------------------------------------------
module multi_line_one_wire_master_top_test;

    import owm_pkg::*;

    // Kinds the block must ignore
    localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    // Register index outside the timing bank
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;

    localparam logic [CFG_W-1:0] POWER_ON_TIMING [CFG_COUNT] = '{
        10'd2, 10'd60, 10'd13, 10'd50, 10'd250, 10'd550, 10'd70, 10'd300
    };

    localparam int  MANY    = 1000000;
    localparam bit  CHECK   = 1'b1;
    localparam bit  PREDICT = 1'b0;

    typedef struct packed {
        logic [7:0] dir_mask;
        logic [7:0] lvl_mask;
        logic       busy;
        logic       done;
        logic [7:0] res_mask;
        logic       rejected;
    } bus_result_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        lines;
        logic              wval;
        logic [7:0]        pins;
        logic [11:0]       reps;
        logic              typed;
        bus_result_t       want;
    } stim_row_t;

    localparam bus_result_t QUIET = '0;

    // Slots use power-on timing, write 2 + 60 and read 2 + 13 + 50 ticks; the
    // reset phases are shortened to 3 + 4 + 2 + 3 + 3 ticks.
    localparam int DIRECTED_ROWS = 23;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{KIND_TICK,    8'hFF, 1'b1, 8'hFF, 12'd1,    CHECK,   QUIET},
        '{KIND_RELEASE, 8'hFF, 1'b0, 8'h00, 12'd1,    CHECK,
          '{8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0}},
        '{KIND_SPARE_5, 8'hFF, 1'b1, 8'hFF, 12'd1,    CHECK,   QUIET},
        '{KIND_SPARE_7, 8'h00, 1'b0, 8'h00, 12'd1,    CHECK,   QUIET},
        '{KIND_RESET,   8'hA5, 1'b0, 8'h00, 12'd1,    CHECK,
          '{8'h00, 8'hA5, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{KIND_READ,    8'hFF, 1'b1, 8'hFF, 12'd1,    CHECK,
          '{8'h00, 8'hA5, 1'b1, 1'b0, 8'h00, 1'b1}},
        '{KIND_TICK,    8'h00, 1'b0, 8'hFF, 12'd3,    PREDICT, QUIET},
        '{KIND_RELEASE, 8'h0F, 1'b0, 8'h00, 12'd1,    PREDICT, QUIET},
        '{KIND_TICK,    8'h00, 1'b0, 8'hFF, 12'd4,    PREDICT, QUIET},
        '{KIND_TICK,    8'h00, 1'b0, 8'h0F, 12'd2,    PREDICT, QUIET},
        '{KIND_TICK,    8'h00, 1'b0, 8'h3F, 12'd3,    PREDICT, QUIET},
        '{KIND_TICK,    8'h00, 1'b0, 8'h55, 12'd3,    PREDICT, QUIET},
        '{KIND_WRITE,   8'h0F, 1'b0, 8'h00, 12'd1,    PREDICT, QUIET},
        '{KIND_TICK,    8'h00, 1'b0, 8'hAA, 12'd62,   PREDICT, QUIET},
        '{KIND_WRITE,   8'hF0, 1'b1, 8'h00, 12'd1,    PREDICT, QUIET},
        '{KIND_SPARE_5, 8'hFF, 1'b1, 8'hFF, 12'd1,    PREDICT, QUIET},
        '{KIND_TICK,    8'h00, 1'b0, 8'hAA, 12'd62,   PREDICT, QUIET},
        '{KIND_READ,    8'h3C, 1'b0, 8'h00, 12'd1,    PREDICT, QUIET},
        '{KIND_TICK,    8'h00, 1'b0, 8'h99, 12'd15,   PREDICT, QUIET},
        '{KIND_TICK,    8'h00, 1'b0, 8'h00, 12'd50,   PREDICT, QUIET},
        '{KIND_RESET,   8'h00, 1'b0, 8'h00, 12'd1,    PREDICT, QUIET},
        '{KIND_TICK,    8'h00, 1'b0, 8'h00, 12'd15,   PREDICT, QUIET},
        '{KIND_RELEASE, 8'hFF, 1'b0, 8'h00, 12'd1,    CHECK,
          '{8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0}}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [KIND_W-1:0]    s_kind;
    logic [7:0]           s_line_mask;
    logic                 s_write_value;
    logic [7:0]           s_pin_levels;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_direction_mask;
    logic [7:0]           m_level_mask;
    logic                 m_busy_res;
    logic                 m_done_res;
    logic [7:0]           m_result_mask;
    logic                 m_rejected;

    multi_line_one_wire_master_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_line_mask      (s_line_mask),
        .s_write_value    (s_write_value),
        .s_pin_levels     (s_pin_levels),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_direction_mask (m_direction_mask),
        .m_level_mask     (m_level_mask),
        .m_busy_res       (m_busy_res),
        .m_done_res       (m_done_res),
        .m_result_mask    (m_result_mask),
        .m_rejected       (m_rejected)
    );

    // Sequencer model state
    logic [CFG_W-1:0] pr_cfg [CFG_COUNT];
    phase_t           pr_phase;
    logic [9:0]       pr_timer;
    logic [7:0]       pr_level;
    logic [7:0]       pr_dir;
    logic [7:0]       pr_saved_level;
    logic [7:0]       pr_saved_dir;
    logic [7:0]       pr_lines;
    logic [7:0]       pr_sample;
    logic             pr_bit;

    bus_result_t      expected_results [$];
    bus_result_t      want;
    bus_result_t      got;
    bus_result_t      typed_result;
    logic             use_typed;
    logic [CFG_W-1:0] timing_set [CFG_COUNT];

    int tx_idle_pct;
    int rx_idle_pct;
    int error_count;
    int transfers_in;
    int results_checked;
    int turned_away;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Timeout
    initial begin
        #4_000_000;
        $display("multi_line_one_wire_master_top_test: errors");
        $finish;
    end

    // Result channel back-pressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic clear_model();
        int i;
        for (i = 0; i < CFG_COUNT; i++) pr_cfg[i] = POWER_ON_TIMING[i];
        pr_phase       = PH_IDLE;
        pr_timer       = '0;
        pr_level       = '0;
        pr_dir         = '0;
        pr_saved_level = '0;
        pr_saved_dir   = '0;
        pr_lines       = '0;
        pr_sample      = '0;
        pr_bit         = 1'b0;
    endtask

    task automatic start_phase(input phase_t ph, input logic [CFG_IDX_W-1:0] sel);
        pr_phase = ph;
        pr_timer = pr_cfg[sel[CFG_SEL_W-1:0]];
    endtask

    // End the running phase; flag done when the command completes
    task automatic close_phase(input logic [7:0] pins, output logic done,
                               output logic [7:0] res);
        logic [7:0] present;
        done = 1'b0;
        res  = '0;
        case (pr_phase)
            PH_W_LOW: begin
                if (pr_bit) pr_level = pr_saved_level;
                start_phase(PH_W_SLOT, REG_WSLOT);
            end
            PH_W_SLOT: begin
                pr_level = pr_saved_level;
                pr_phase = PH_IDLE;
                done     = 1'b1;
            end
            PH_R_LOW: begin
                pr_level = pr_saved_level;
                pr_dir   = pr_saved_dir & ~pr_lines;
                start_phase(PH_R_SAMPLE, REG_RSAMPLE);
            end
            PH_R_SAMPLE: begin
                pr_sample = pins & pr_lines;
                start_phase(PH_R_SLOT, REG_RSLOT);
            end
            PH_R_SLOT: begin
                pr_dir   = pr_saved_dir;
                pr_phase = PH_IDLE;
                done     = 1'b1;
                res      = pr_sample;
            end
            PH_RS_HIGH: begin
                pr_dir   = pr_saved_dir | pr_lines;
                pr_level = pr_saved_level & ~pr_lines;
                start_phase(PH_RS_LOW, REG_RLOW);
            end
            PH_RS_LOW: begin
                pr_dir   = pr_saved_dir & ~pr_lines;
                pr_level = pr_saved_level | pr_lines;
                start_phase(PH_RS_PSAMPLE, REG_PSAMPLE);
            end
            PH_RS_PSAMPLE: begin
                pr_sample = pins;
                start_phase(PH_RS_PCHECK, REG_PCHECK);
            end
            PH_RS_PCHECK: begin
                pr_sample = pr_sample | ~pins;
                start_phase(PH_RS_TAIL, REG_RHIGH);
            end
            PH_RS_TAIL: begin
                // present: low at the sample and back high at the check
                present  = ~pr_sample & pr_lines;
                pr_dir   = pr_saved_dir | present;
                pr_level = pr_saved_level | present;
                pr_phase = PH_IDLE;
                done     = 1'b1;
                res      = present;
            end
            default: pr_phase = PH_IDLE;
        endcase
    endtask

    // Advance the model by one input transfer and return its result
    task automatic advance_bus_model(input logic [KIND_W-1:0] kind, input logic [7:0] mask,
                                     input logic wval, input logic [7:0] pins,
                                     output bus_result_t r);
        logic       busy;
        logic       done;
        logic       rej;
        logic [7:0] res;
        busy = (pr_phase != PH_IDLE);
        done = 1'b0;
        rej  = 1'b0;
        res  = '0;
        case (kind)
            KIND_TICK: begin
                if (busy) begin
                    if (pr_timer != 0) pr_timer = pr_timer - 1'b1;
                    if (pr_timer == 0) close_phase(pins, done, res);
                end
            end
            KIND_RESET, KIND_WRITE, KIND_READ, KIND_RELEASE: begin
                if (busy) begin
                    rej = 1'b1;
                end else begin
                    pr_lines       = mask;
                    pr_saved_level = pr_level;
                    pr_saved_dir   = pr_dir;
                    case (kind)
                        KIND_RESET: begin
                            pr_level = pr_saved_level | mask;
                            start_phase(PH_RS_HIGH, REG_RHIGH);
                        end
                        KIND_WRITE: begin
                            pr_bit   = wval;
                            pr_level = pr_saved_level & ~mask;
                            start_phase(PH_W_LOW, REG_RECOVERY);
                        end
                        KIND_READ: begin
                            pr_level = pr_saved_level & ~mask;
                            start_phase(PH_R_LOW, REG_RECOVERY);
                        end
                        default: begin
                            pr_dir   = pr_dir & ~mask;
                            pr_level = pr_level & ~mask;
                            done     = 1'b1;
                        end
                    endcase
                end
            end
            default: ;
        endcase
        r.dir_mask = pr_dir;
        r.lvl_mask = pr_level;
        r.busy     = (pr_phase != PH_IDLE);
        r.done     = done;
        r.res_mask = done ? res : 8'h00;
        r.rejected = rej;
    endtask

    task automatic log_mismatch(input string what, input bus_result_t w, input bus_result_t g);
        error_count++;
        if (error_count <= 10) begin
            $write("%0t %s: expected dir %h lvl %h busy %b done %b res %h rej %b",
                   $realtime, what, w.dir_mask, w.lvl_mask, w.busy, w.done, w.res_mask,
                   w.rejected);
            $display(", got dir %h lvl %h busy %b done %b res %h rej %b",
                     g.dir_mask, g.lvl_mask, g.busy, g.done, g.res_mask, g.rejected);
        end
    endtask

    // Track every transfer on the three channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready && cfg_index < CFG_COUNT)
                pr_cfg[cfg_index[CFG_SEL_W-1:0]] = cfg_data;
            if (s_valid && s_ready) begin
                advance_bus_model(s_kind, s_line_mask, s_write_value, s_pin_levels, want);
                if (want.rejected) turned_away++;
                if (use_typed) want = typed_result;
                expected_results.push_back(want);
                transfers_in++;
            end
            if (m_valid && m_ready) begin
                got.dir_mask = m_direction_mask;
                got.lvl_mask = m_level_mask;
                got.busy     = m_busy_res;
                got.done     = m_done_res;
                got.res_mask = m_result_mask;
                got.rejected = m_rejected;
                if (expected_results.size() == 0) begin
                    log_mismatch("result with nothing pending", QUIET, got);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.dir_mask !== want.dir_mask || got.lvl_mask !== want.lvl_mask ||
                        got.busy !== want.busy || got.done !== want.done ||
                        got.res_mask !== want.res_mask || got.rejected !== want.rejected)
                        log_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Offer one item at a falling edge, hold it until the transfer
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [7:0] mask,
                             input logic wval, input logic [7:0] pins,
                             input logic typed, input bus_result_t w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_kind        <= kind;
        s_line_mask   <= mask;
        s_write_value <= wval;
        s_pin_levels  <= pins;
        s_valid       <= 1'b1;
        use_typed      = typed;
        typed_result   = w;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Drop valid and wait until every result has been taken
    task automatic settle_bus();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_results.size() != 0);
    endtask

    task automatic write_timing(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
    endtask

    task automatic program_timing(input logic [CFG_W-1:0] vals [CFG_COUNT]);
        int i;
        for (i = 0; i < CFG_COUNT; i++) write_timing(CFG_IDX_W'(i), vals[i]);
        write_timing(REG_SPARE, ~vals[0]);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [KIND_W-1:0] random_command();
        int pick;
        pick = $urandom_range(9);
        if (pick < 3) return KIND_RESET;
        if (pick < 6) return KIND_WRITE;
        if (pick < 9) return KIND_READ;
        return KIND_RELEASE;
    endfunction

    function automatic logic [7:0] random_lines();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [KIND_W-1:0] random_spare();
        int pick;
        pick = $urandom_range(2);
        if (pick == 0) return KIND_SPARE_5;
        if (pick == 1) return KIND_SPARE_6;
        return KIND_SPARE_7;
    endfunction

    // Command sequences run to completion under random pin levels, with
    // stray commands, spare kinds and idle ticks mixed in
    task automatic run_random(input int item_goal, input int cmd_goal);
        int items;
        int cmds;
        int pick;
        items = 0;
        cmds  = 0;
        while (items < item_goal && cmds < cmd_goal) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                send_item(random_spare(), random_lines(), 1'($urandom_range(1)),
                          8'($urandom_range(255)), PREDICT, QUIET);
            end else if (pick < 10) begin
                send_item(KIND_TICK, random_lines(), 1'($urandom_range(1)),
                          8'($urandom_range(255)), PREDICT, QUIET);
            end else begin
                send_item(random_command(), random_lines(), 1'($urandom_range(1)),
                          8'($urandom_range(255)), PREDICT, QUIET);
                items++;
                cmds++;
                while (pr_phase != PH_IDLE) begin
                    pick = $urandom_range(99);
                    if (pick < 5) begin
                        send_item(random_command(), random_lines(), 1'($urandom_range(1)),
                                  8'($urandom_range(255)), PREDICT, QUIET);
                        items++;
                    end else if (pick < 8) begin
                        send_item(random_spare(), random_lines(), 1'($urandom_range(1)),
                                  8'($urandom_range(255)), PREDICT, QUIET);
                    end else begin
                        send_item(KIND_TICK, random_lines(), 1'($urandom_range(1)),
                                  8'($urandom_range(255)), PREDICT, QUIET);
                        items++;
                    end
                end
            end
        end
    endtask

    initial begin
        int i;
        int k;
        int pick;
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_kind          = KIND_TICK;
        s_line_mask     = '0;
        s_write_value   = 1'b0;
        s_pin_levels    = '0;
        use_typed       = 1'b0;
        typed_result    = QUIET;
        error_count     = 0;
        transfers_in    = 0;
        results_checked = 0;
        turned_away     = 0;
        tx_idle_pct     = 14;
        rx_idle_pct     = 88;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Shorten the reset phases, keep the power-on slot timing
        write_timing(REG_RHIGH,   CFG_W'(3));
        write_timing(REG_RLOW,    CFG_W'(4));
        write_timing(REG_PSAMPLE, CFG_W'(2));
        write_timing(REG_PCHECK,  CFG_W'(3));
        cfg_valid <= 1'b0;

        // Directed table
        for (i = 0; i < DIRECTED_ROWS; i++)
            for (k = 0; k < DIRECTED[i].reps; k++)
                send_item(DIRECTED[i].kind, DIRECTED[i].lines, DIRECTED[i].wval,
                          DIRECTED[i].pins, DIRECTED[i].typed, DIRECTED[i].want);
        settle_bus();

        // Short random timing
        for (i = 0; i < CFG_COUNT; i++) timing_set[i] = CFG_W'($urandom_range(3));
        program_timing(timing_set);
        run_random(60, MANY);
        settle_bus();

        // All phases end on the first tick; swap the stall pattern
        tx_idle_pct = 88;
        rx_idle_pct = 14;
        for (i = 0; i < CFG_COUNT; i++) timing_set[i] = '0;
        program_timing(timing_set);
        run_random(60, MANY);
        settle_bus();

        // Mixed zero, one and short timing, no stalls
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (i = 0; i < CFG_COUNT; i++) begin
            pick = $urandom_range(3);
            timing_set[i] = (pick == 0) ? CFG_W'(0) : (pick == 1) ? CFG_W'(1)
                                                    : CFG_W'($urandom_range(2, 6));
        end
        program_timing(timing_set);
        run_random(60, MANY);
        settle_bus();

        repeat (20) @(negedge aclk);

        $display("%0d transfers in, %0d results checked, %0d commands turned away while busy",
                 transfers_in, results_checked, turned_away);
        $display("timing: power-on slots, short random, all zero, mixed; %0d mismatches",
                 error_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("multi_line_one_wire_master_top_test: clean");
        end else begin
            $display("multi_line_one_wire_master_top_test: errors");
        end
        $finish;
    end

endmodule
